// ===== rtl/core/tst_pkg.sv =====
`timescale 1ns / 1ps
package tst_pkg;

	typedef logic [12:0] tenths_t;
	typedef logic [8:0]  degrees_t;
	typedef logic [6:0]  duty_t;
	typedef logic [15:0] sum6_t;
	typedef logic [9:0]  whole_t;

	typedef enum logic [1:0] {
		CFG_HEAT_THRESHOLD = 2'd0,
		CFG_DUTY_HEAT      = 2'd1,
		CFG_DUTY_IDLE      = 2'd2
	} cfg_index_t;

	localparam int CFG_DATA_W = 13;

	localparam tenths_t HEAT_THRESHOLD_RST = 13'd375;
	localparam duty_t   DUTY_HEAT_RST      = 7'd16;
	localparam duty_t   DUTY_IDLE_RST      = 7'd100;

	localparam logic [9:0]  CONV_SCALE  = 10'd546;
	localparam logic [16:0] CONV_OFFSET = 17'd67840;
	localparam logic [19:0] SAT_LIMIT   = 20'd819200;
	localparam logic [20:0] RECIP_100   = 21'd1342178;
	localparam logic [15:0] RECIP_6     = 16'd43691;
	localparam logic [12:0] RECIP_10    = 13'd6554;

	localparam tenths_t  TENTHS_MAX  = 13'd8191;
	localparam degrees_t DEGREES_MAX = 9'd511;
	localparam logic [3:0] ROUND_LIMIT = 4'd6;

endpackage

// ===== rtl/core/tst_tenths.sv =====
`timescale 1ns / 1ps
module tst_tenths
	import tst_pkg::*;
#(
	parameter int SCALED_W = 20
) (
	input  logic [SCALED_W-1:0] scaled,
	output tenths_t             tenths
);

	localparam int DIFF_W = (SCALED_W > 20) ? SCALED_W : 20;

	logic [DIFF_W-1:0] wide;
	logic [DIFF_W-1:0] diff;
	logic [40:0]       prod;

	assign wide = DIFF_W'(scaled);
	assign diff = wide - DIFF_W'(CONV_OFFSET);
	assign prod = 41'(diff[19:0]) * 41'(RECIP_100);

	always_comb begin
		if (wide < DIFF_W'(CONV_OFFSET)) begin
			tenths = '0;
		end else if (diff >= DIFF_W'(SAT_LIMIT)) begin
			tenths = TENTHS_MAX;
		end else begin
			tenths = prod[39:27];
		end
	end

endmodule

// ===== rtl/core/tst_degrees.sv =====
`timescale 1ns / 1ps
module tst_degrees
	import tst_pkg::*;
(
	input  tenths_t  smoothed,
	output degrees_t degrees
);

	logic [25:0] prod;
	whole_t      whole;
	logic [12:0] frac_full;
	logic [3:0]  frac;
	logic [10:0] rounded;

	assign prod      = 26'(smoothed) * 26'(RECIP_10);
	assign whole     = prod[25:16];
	assign frac_full = smoothed - {whole, 3'b000} - {2'b00, whole, 1'b0};
	assign frac      = frac_full[3:0];
	assign rounded   = 11'(whole) + ((frac > ROUND_LIMIT) ? 11'd1 : 11'd0);

	always_comb begin
		if (rounded > 11'(DEGREES_MAX)) begin
			degrees = DEGREES_MAX;
		end else begin
			degrees = rounded[8:0];
		end
	end

endmodule

// ===== rtl/core/temperature_smoothing_thermostat.sv =====
`timescale 1ns / 1ps
// channel   | handshake                   | payload
// ----------+-----------------------------+-----------------------------------------
// sample    | sample_valid / sample_stall | sample_code
// result    | result_valid / result_stall | smoothed_tenths, rounded_degrees,
//           |                             | heater_on, duty_count
// config    | cfg_write                   | cfg_index, cfg_data
//
// One item per cycle sustained while result_stall does not hold the pipeline.
// Stages: sample scale, tenths conversion, smoothing update, rounding and heater.
// arst_n clears all history, smoothed value and valid bits; config gets defaults.
// A stalled result holds only the stages behind it that are full; bubbles still fill.
module temperature_smoothing_thermostat
	import tst_pkg::*;
#(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  logic [SAMPLE_BITS-1:0] sample_code,
	output logic                   result_valid,
	input  logic                   result_stall,
	output tenths_t                smoothed_tenths,
	output degrees_t               rounded_degrees,
	output logic                   heater_on,
	output duty_t                  duty_count,
	input  logic                   cfg_write,
	input  logic [1:0]             cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int SUM4_W   = SAMPLE_BITS + 2;
	localparam int SCALED_W = SAMPLE_BITS + 10;

	tenths_t heat_threshold_q;
	duty_t   duty_heat_q;
	duty_t   duty_idle_q;

	logic [SAMPLE_BITS-1:0] sample_hist_q [3];
	tenths_t                conv_hist_q [5];
	tenths_t                latest_conv_q;
	tenths_t                smoothed_q;

	logic                v_s1;
	logic                v_s2;
	logic                v_s3;
	logic [SCALED_W-1:0] scaled_s1;
	tenths_t             conv_s2;

	logic ready_o;
	logic ready3;
	logic ready2;
	logic ready1;
	logic accept;

	logic [SUM4_W-1:0]      sum4;
	logic [SAMPLE_BITS-1:0] avg;
	logic [SCALED_W-1:0]    scaled;
	tenths_t                conv;
	sum6_t                  sum6;
	logic [31:0]            prod6;
	tenths_t                smoothed_next;
	degrees_t               degrees;
	logic                   heat;

	assign ready_o      = !result_valid || !result_stall;
	assign ready3       = !v_s3 || ready_o;
	assign ready2       = !v_s2 || ready3;
	assign ready1       = !v_s1 || ready2;
	assign sample_stall = !ready1;
	assign accept       = sample_valid && ready1;

	assign sum4 = SUM4_W'(sample_code) + SUM4_W'(sample_hist_q[0]) +
		SUM4_W'(sample_hist_q[1]) + SUM4_W'(sample_hist_q[2]);
	assign avg    = sum4[SUM4_W-1:2];
	assign scaled = SCALED_W'(avg) * SCALED_W'(CONV_SCALE);

	tst_tenths #(
		.SCALED_W(SCALED_W)
	) u_tenths (
		.scaled(scaled_s1),
		.tenths(conv)
	);

	assign sum6 = sum6_t'(smoothed_q) + sum6_t'(latest_conv_q) +
		sum6_t'(conv_hist_q[0]) + sum6_t'(conv_hist_q[1]) +
		sum6_t'(conv_hist_q[2]) + sum6_t'(conv_hist_q[3]);
	assign prod6         = 32'(sum6) * 32'(RECIP_6);
	assign smoothed_next = prod6[30:18];

	tst_degrees u_degrees (
		.smoothed(smoothed_q),
		.degrees (degrees)
	);

	assign heat = smoothed_q < heat_threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heat_threshold_q <= HEAT_THRESHOLD_RST;
			duty_heat_q      <= DUTY_HEAT_RST;
			duty_idle_q      <= DUTY_IDLE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_HEAT_THRESHOLD: heat_threshold_q <= cfg_data[12:0];
				CFG_DUTY_HEAT:      duty_heat_q      <= cfg_data[6:0];
				CFG_DUTY_IDLE:      duty_idle_q      <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// scale stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				sample_hist_q[i] <= '0;
			end
		end else if (ready1) begin
			v_s1 <= sample_valid;
			if (sample_valid) begin
				sample_hist_q[0] <= sample_code;
				sample_hist_q[1] <= sample_hist_q[0];
				sample_hist_q[2] <= sample_hist_q[1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			scaled_s1 <= scaled;
		end
	end

	// conversion stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready2 && v_s1) begin
			conv_s2 <= conv;
		end
	end

	// smoothing stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3          <= 1'b0;
			latest_conv_q <= '0;
			smoothed_q    <= '0;
			for (int i = 0; i < 5; i++) begin
				conv_hist_q[i] <= '0;
			end
		end else if (ready3) begin
			v_s3 <= v_s2;
			if (v_s2) begin
				conv_hist_q[0] <= latest_conv_q;
				for (int i = 1; i < 5; i++) begin
					conv_hist_q[i] <= conv_hist_q[i-1];
				end
				latest_conv_q <= conv_s2;
				smoothed_q    <= smoothed_next;
			end
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (ready_o) begin
			result_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && v_s3) begin
			smoothed_tenths <= smoothed_q;
			rounded_degrees <= degrees;
			heater_on       <= heat;
			duty_count      <= heat ? duty_heat_q : duty_idle_q;
		end
	end

`ifndef SYNTHESIS
	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s1 && !v_s2 && !v_s3 && !result_valid) |-> !sample_stall)
		else $error("empty pipeline refuses an item");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s2 && ready3) |=> ($stable(smoothed_q) && $stable(latest_conv_q)))
		else $error("smoothing state moved without an item");

	a_result_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && ready_o) |=> result_valid)
		else $error("smoothed item lost before result register");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import tst_pkg::*;

	localparam int SAMPLE_W       = 10;
	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 11;
	localparam int DRAIN_CYCLES   = 12;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int PRESSURE_ITEMS = 60;
	localparam int RANDOM_PHASES  = 12;
	localparam int PHASE_ITEMS    = 155;
	localparam int PRINT_LIMIT    = 50;

	localparam logic [1:0] CFG_INDEX_UNUSED = 2'd3;

	localparam logic [SAMPLE_W-1:0] CODE_MAX      = '1;
	localparam logic [SAMPLE_W-1:0] CODE_BELOW_0C = 10'd124;
	localparam logic [SAMPLE_W-1:0] CODE_ABOVE_0C = 10'd125;

	typedef struct packed {
		tenths_t  tenths;
		degrees_t degrees;
		logic     heat;
		duty_t    duty;
	} reading_t;

	logic                   clk;
	logic                   arst_n       = 1'b0;
	logic                   sample_valid = 1'b0;
	logic                   sample_stall;
	logic [SAMPLE_W-1:0]    sample_code  = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	tenths_t                smoothed_tenths;
	degrees_t               rounded_degrees;
	logic                   heater_on;
	duty_t                  duty_count;
	logic                   cfg_write    = 1'b0;
	logic [1:0]             cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;

	reading_t expected_readings[$];
	int       mismatches   = 0;
	int       idle_cycles  = 0;
	int       hold_left    = 0;
	int       burst_left   = 0;
	bit       idle_en      = 1'b1;

	logic [SAMPLE_W-1:0] samples_seen[4] = '{default: '0};
	tenths_t             convs_seen[5]   = '{default: '0};
	tenths_t             newest_conv     = '0;
	tenths_t             smooth_now      = '0;
	tenths_t             thr_reg         = HEAT_THRESHOLD_RST;
	duty_t               heat_duty_reg   = DUTY_HEAT_RST;
	duty_t               idle_duty_reg   = DUTY_IDLE_RST;

	temperature_smoothing_thermostat #(
		.SAMPLE_BITS(SAMPLE_W)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.sample_code    (sample_code),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.smoothed_tenths(smoothed_tenths),
		.rounded_degrees(rounded_degrees),
		.heater_on      (heater_on),
		.duty_count     (duty_count),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic reading_t smooth_step(input logic [SAMPLE_W-1:0] code);
		int unsigned avg, scaled, conv, total, whole, frac, deg;
		int i;
		reading_t r;
		for (i = 3; i > 0; i--)
			samples_seen[i] = samples_seen[i-1];
		samples_seen[0] = code;
		avg = (int'(samples_seen[0]) + int'(samples_seen[1]) +
		       int'(samples_seen[2]) + int'(samples_seen[3])) / 4;
		scaled = avg * 546;
		if (scaled < 67840)
			conv = 0;
		else
			conv = (scaled - 67840) / 100;
		if (conv > TENTHS_MAX)
			conv = TENTHS_MAX;
		for (i = 4; i > 0; i--)
			convs_seen[i] = convs_seen[i-1];
		convs_seen[0] = newest_conv;
		newest_conv = tenths_t'(conv);
		total = smooth_now;
		for (i = 0; i < 5; i++)
			total += convs_seen[i];
		smooth_now = tenths_t'(total / 6);
		whole = smooth_now / 10;
		frac = smooth_now - whole * 10;
		deg = (frac > 6) ? whole + 1 : whole;
		if (deg > DEGREES_MAX)
			deg = DEGREES_MAX;
		r.tenths  = smooth_now;
		r.degrees = degrees_t'(deg);
		r.heat    = smooth_now < thr_reg;
		r.duty    = r.heat ? heat_duty_reg : idle_duty_reg;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < PRINT_LIMIT)
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		mismatches++;
	endtask

	task automatic send_sample(input logic [SAMPLE_W-1:0] code);
		int gap;
		if (idle_en && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 12);
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_code <= code;
		do @(posedge clk); while (sample_stall);
		expected_readings.push_back(smooth_step(code));
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_HEAT_THRESHOLD: thr_reg = data;
			CFG_DUTY_HEAT:      heat_duty_reg = data[6:0];
			CFG_DUTY_IDLE:      idle_duty_reg = data[6:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain_results();
		sample_valid <= 1'b0;
		while (expected_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// check each accepted result against the oldest prediction
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_readings.size() == 0) begin
				report_mismatch("unexpected result, smoothed_tenths", smoothed_tenths, 0);
			end else begin
				want = expected_readings.pop_front();
				if (smoothed_tenths !== want.tenths)
					report_mismatch("smoothed_tenths", smoothed_tenths, want.tenths);
				if (rounded_degrees !== want.degrees)
					report_mismatch("rounded_degrees", rounded_degrees, want.degrees);
				if (heater_on !== want.heat)
					report_mismatch("heater_on", heater_on, want.heat);
				if (duty_count !== want.duty)
					report_mismatch("duty_count", duty_count, want.duty);
			end
		end
	end

	// hold off the result side: long hold on request, else random bursts while idle_en is set
	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else if (burst_left > 0) begin
			result_stall <= 1'b1;
			burst_left--;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			result_stall <= 1'b1;
			burst_left = $urandom_range(1, 12) - 1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_write || (sample_valid && !sample_stall) ||
		    (result_valid && !result_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[temperature_smoothing_thermostat] ERROR");
			$finish;
		end
	end

	task automatic test_reset_defaults();
		int n;
		for (n = 0; n < 4; n++)
			send_sample('0);
		for (n = 0; n < 4; n++)
			send_sample(CODE_BELOW_0C);
		for (n = 0; n < 4; n++)
			send_sample(CODE_ABOVE_0C);
		for (n = 0; n < 5; n++)
			send_sample(CODE_MAX);
		drain_results();
	endtask

	task automatic test_register_extremes();
		int n;
		write_reg(CFG_HEAT_THRESHOLD, TENTHS_MAX);
		write_reg(CFG_DUTY_HEAT, 13'h1FFF);
		write_reg(CFG_DUTY_IDLE, 13'h1F80);
		write_reg(CFG_INDEX_UNUSED, 13'h0AAA);
		for (n = 0; n < 4; n++)
			send_sample(CODE_MAX);
		drain_results();
		write_reg(CFG_HEAT_THRESHOLD, '0);
		write_reg(CFG_INDEX_UNUSED, 13'h1555);
		for (n = 0; n < 4; n++)
			send_sample(n[0] ? CODE_MAX : '0);
		drain_results();
	endtask

	task automatic test_backpressure();
		int n;
		idle_en = 1'b0;
		hold_left = HOLD_CYCLES;
		for (n = 0; n < PRESSURE_ITEMS; n++)
			send_sample(SAMPLE_W'($urandom_range(0, CODE_MAX)));
		drain_results();
		idle_en = 1'b1;
	endtask

	task automatic test_random_phases();
		int phase, n, style, drift;
		logic [SAMPLE_W-1:0] code;
		drift = 512;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 3))
				0:       write_reg(CFG_HEAT_THRESHOLD, '0);
				1:       write_reg(CFG_HEAT_THRESHOLD,
					CFG_DATA_W'($urandom_range(0, TENTHS_MAX)));
				default: write_reg(CFG_HEAT_THRESHOLD, CFG_DATA_W'($urandom_range(0, 5000)));
			endcase
			write_reg(CFG_DUTY_HEAT, CFG_DATA_W'($urandom_range(0, 8191)));
			write_reg(CFG_DUTY_IDLE, CFG_DATA_W'($urandom_range(0, 8191)));
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_INDEX_UNUSED, CFG_DATA_W'($urandom_range(0, 8191)));
			idle_en = (phase < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
			style = $urandom_range(0, 2);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				case (style)
					0: code = SAMPLE_W'($urandom_range(0, CODE_MAX));
					1: begin
						drift += $urandom_range(0, 40) - 20;
						if (drift < 0)
							drift = 0;
						if (drift > CODE_MAX)
							drift = CODE_MAX;
						code = SAMPLE_W'(drift);
					end
					default: begin
						case ($urandom_range(0, 4))
							0:       code = '0;
							1:       code = CODE_MAX;
							2:       code = CODE_BELOW_0C;
							3:       code = CODE_ABOVE_0C;
							default: code = SAMPLE_W'($urandom_range(0, CODE_MAX));
						endcase
					end
				endcase
				send_sample(code);
			end
			drain_results();
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_backpressure();
		test_random_phases();
		if (expected_readings.size() != 0)
			report_mismatch("results missing at end", 0, expected_readings.size());
		if (mismatches == 0)
			$display("[temperature_smoothing_thermostat] OK");
		else
			$display("[temperature_smoothing_thermostat] ERROR");
		$finish;
	end

endmodule
